@@ src/assert_macros.svh @@
// Assertion macros shared by the RTL files of the LED chaser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside of reset.
`define LCBS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checked on every rising clock edge, reset included.
`define LCBS_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

@@ src/lcbs_pkg.sv @@
`default_nettype none

package lcbs_pkg;

   localparam int PERIOD_W  = 16;
   localparam int CFG_W     = 10;
   localparam int TICK_W    = 7;
   localparam int LED_OUT_W = 8;

   localparam logic [CFG_W-1:0]    MIN_PERIOD_RESET = 10'd10;
   localparam logic [CFG_W-1:0]    STEP_RESET       = 10'd50;
   localparam logic [CFG_W-1:0]    DEBOUNCE_RESET   = 10'd40;
   localparam logic [TICK_W-1:0]   TICK_RESET       = 7'd5;
   localparam logic [PERIOD_W-1:0] PERIOD_RESET     = 16'd150;

   typedef enum logic [1:0] {
      CSR_MIN_PERIOD = 2'd0,
      CSR_STEP       = 2'd1,
      CSR_DEBOUNCE   = 2'd2,
      CSR_TICK       = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic fast_pressed;
      logic slow_pressed;
   } req_type;

   typedef struct packed {
      logic [LED_OUT_W-1:0] led_pattern;
      logic [PERIOD_W-1:0]  current_period_ms;
      logic                 led_advanced;
   } rsp_type;

   typedef struct packed {
      logic              sample_en;
      logic              level;
      logic              other_level;
      logic [TICK_W-1:0] chunk_ms;
      logic [CFG_W-1:0]  settle_ms;
   } btn_ctl_type;

endpackage

`default_nettype wire

@@ src/lcbs_button.sv @@
`default_nettype none
`include "assert_macros.svh"

module lcbs_button (
   input  wire                 clock,
   input  wire                 reset,
   input  lcbs_pkg::btn_ctl_type ctl,
   output logic                press
);
   import lcbs_pkg::*;

   logic                last_level_ff, last_level_in;
   logic [PERIOD_W-1:0] stable_ff, stable_in;
   logic                locked_ff, locked_in;
   logic [PERIOD_W:0]   stable_sum;
   logic                stable_ok;
   logic                release_ok;

   always_comb begin
      stable_sum = {1'b0, stable_ff} + (PERIOD_W+1)'(ctl.chunk_ms);
      if (ctl.level == last_level_ff) begin
         stable_in = stable_sum[PERIOD_W] ? '1 : stable_sum[PERIOD_W-1:0];
      end else begin
         stable_in = '0;
      end
      last_level_in = ctl.level;
      stable_ok     = stable_in >= PERIOD_W'(ctl.settle_ms);
      press         = ctl.sample_en & ctl.level & stable_ok & ~locked_ff & ~ctl.other_level;
      release_ok    = ~ctl.level & locked_ff & stable_ok;
      if (press) begin
         locked_in = 1'b1;
      end else if (release_ok) begin
         locked_in = 1'b0;
      end else begin
         locked_in = locked_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_level_ff <= 1'b0;
         stable_ff     <= '0;
         locked_ff     <= 1'b0;
      end else if (ctl.sample_en) begin
         last_level_ff <= last_level_in;
         stable_ff     <= stable_in;
         locked_ff     <= locked_in;
      end
   end

   `LCBS_ASSERT(a_press_locks, press |=> locked_ff, "press did not lock the button")
   `LCBS_ASSERT(a_idle_stable, !ctl.sample_en |=> $stable(stable_ff), "stable time moved idle")
   `LCBS_ASSERT(a_idle_lock, !ctl.sample_en |=> $stable(locked_ff), "lock moved without a sample")

endmodule

`default_nettype wire

@@ src/led_chaser_button_speed_core.sv @@
// Running-light driver with two debounced speed buttons.
// Input channel (req_*): one item is one sample of the fast and slow buttons,
// each sample closing a chunk of min(time left, tick) milliseconds.
// Result channel (rsp_*): one item per sample with the one-hot LED pattern,
// the step period in force and a flag set when the LED moved on that sample.
// Configuration (csr_*): minimum period, step, debounce time and tick length,
// written while no item is in flight.
// Latency: a result is presented in the cycle after its sample is accepted.
// Throughput: one sample per cycle when not stalled; all the work for a
// sample is done by the logic between the state registers and the result register.
// Reset: the lowest LED is lit, the period and countdown are 150 ms, the
// buttons read released and unlocked, and the registers take their defaults.
// While the result side stalls, the result register holds its item and the
// input side is stalled; it reopens in the cycle the result is taken.
`default_nettype none
`include "assert_macros.svh"

module led_chaser_button_speed_core #(
   parameter int LED_COUNT = 8
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         req_valid,
   output logic                        req_stall,
   input  lcbs_pkg::req_type           req_data,
   output logic                        rsp_valid,
   input  wire                         rsp_stall,
   output lcbs_pkg::rsp_type           rsp_data,
   input  wire                         csr_we,
   input  lcbs_pkg::csr_index_type     csr_index,
   input  wire [lcbs_pkg::CFG_W-1:0]   csr_wdata
);
   import lcbs_pkg::*;

   localparam int PAD_W = (LED_COUNT >= LED_OUT_W) ? LED_COUNT : LED_OUT_W;

   logic [CFG_W-1:0]     min_period_ff, step_ff, debounce_ff;
   logic [TICK_W-1:0]    tick_ff;
   logic [LED_COUNT-1:0] lit_ff, lit_in;
   logic [PERIOD_W-1:0]  period_ff, period_in;
   logic [PERIOD_W-1:0]  remaining_ff, remaining_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   logic                 req_accept;
   logic                 both_pressed;
   logic [TICK_W-1:0]    tick_eff;
   logic [CFG_W-1:0]     minp;
   logic [TICK_W-1:0]    chunk;
   logic [PERIOD_W-1:0]  remaining_left;
   logic [CFG_W:0]       fast_limit;
   logic [PERIOD_W-1:0]  fast_period;
   logic [PERIOD_W:0]    slow_sum;
   logic [PERIOD_W-1:0]  slow_period;
   logic                 advance;
   logic [PAD_W-1:0]     lit_pad;
   logic                 fast_press, slow_press;
   btn_ctl_type          fast_ctl, slow_ctl;

   assign req_accept = req_valid & ~req_stall;
   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   always_comb begin
      both_pressed = req_data.fast_pressed & req_data.slow_pressed;
      tick_eff     = (tick_ff == '0) ? TICK_W'(1) : tick_ff;
      minp         = (min_period_ff == '0) ? CFG_W'(1) : min_period_ff;
      chunk        = (remaining_ff < PERIOD_W'(tick_eff)) ? remaining_ff[TICK_W-1:0] : tick_eff;
      remaining_left = remaining_ff - PERIOD_W'(chunk);

      fast_ctl.sample_en   = req_accept & ~both_pressed;
      fast_ctl.level       = req_data.fast_pressed;
      fast_ctl.other_level = req_data.slow_pressed;
      fast_ctl.chunk_ms    = chunk;
      fast_ctl.settle_ms   = debounce_ff;

      slow_ctl.sample_en   = req_accept & ~both_pressed;
      slow_ctl.level       = req_data.slow_pressed;
      slow_ctl.other_level = req_data.fast_pressed;
      slow_ctl.chunk_ms    = chunk;
      slow_ctl.settle_ms   = debounce_ff;
   end

   lcbs_button u_fast (
      .clock (clock),
      .reset (reset),
      .ctl   (fast_ctl),
      .press (fast_press)
   );

   lcbs_button u_slow (
      .clock (clock),
      .reset (reset),
      .ctl   (slow_ctl),
      .press (slow_press)
   );

   always_comb begin
      // A fast press never goes below the minimum, even when the period was
      // already under a minimum that was raised later.
      fast_limit  = {1'b0, minp} + {1'b0, step_ff};
      fast_period = (period_ff > PERIOD_W'(fast_limit)) ?
                    period_ff - PERIOD_W'(step_ff) : PERIOD_W'(minp);
      slow_sum    = {1'b0, period_ff} + (PERIOD_W+1)'(step_ff);
      slow_period = slow_sum[PERIOD_W] ? '1 : slow_sum[PERIOD_W-1:0];

      if (fast_press) begin
         period_in = fast_period;
      end else if (slow_press) begin
         period_in = slow_period;
      end else begin
         period_in = period_ff;
      end

      advance = (remaining_left == '0);
      if (advance) begin
         lit_in       = {lit_ff[LED_COUNT-2:0], lit_ff[LED_COUNT-1]};
         remaining_in = period_in;
      end else begin
         lit_in       = lit_ff;
         remaining_in = remaining_left;
      end

      lit_pad = PAD_W'(lit_in);
      rsp_data_in.led_pattern       = lit_pad[LED_OUT_W-1:0];
      rsp_data_in.current_period_ms = period_in;
      rsp_data_in.led_advanced      = advance;

      rsp_valid_in = req_accept | (rsp_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_period_ff <= MIN_PERIOD_RESET;
         step_ff       <= STEP_RESET;
         debounce_ff   <= DEBOUNCE_RESET;
         tick_ff       <= TICK_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MIN_PERIOD: min_period_ff <= csr_wdata;
            CSR_STEP:       step_ff       <= csr_wdata;
            CSR_DEBOUNCE:   debounce_ff   <= csr_wdata;
            CSR_TICK:       tick_ff       <= csr_wdata[TICK_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lit_ff       <= LED_COUNT'(1);
         period_ff    <= PERIOD_RESET;
         remaining_ff <= PERIOD_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            lit_ff       <= lit_in;
            period_ff    <= period_in;
            remaining_ff <= remaining_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   `LCBS_ASSERT(a_lit_onehot, $onehot(lit_ff), "lit LED is not one-hot")
   `LCBS_ASSERT(a_period_nonzero, period_ff != '0, "period reached zero")
   `LCBS_ASSERT(a_left_nonzero, remaining_ff != '0, "countdown reached zero")
   `LCBS_ASSERT(a_reload, req_accept && advance |=> remaining_ff == period_ff, "missed reload")
   `LCBS_ASSERT(a_result_follows, req_accept |=> rsp_valid_ff, "accepted item produced no result")

endmodule

`default_nettype wire

@@ dv/lcbs_chaser_checker.sv @@
module lcbs_chaser_checker #(
   parameter int LED_COUNT = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  lcbs_pkg::req_type        req_data,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  lcbs_pkg::rsp_type        rsp_data,
   input  logic                     csr_we,
   input  lcbs_pkg::csr_index_type  csr_index,
   input  logic [lcbs_pkg::CFG_W-1:0] csr_wdata,
   output int                       results_owed,
   output int                       mismatches
);
   timeunit 1ns;
   timeprecision 1ps;

   import lcbs_pkg::*;

   // Shadow copies of the settings.
   logic [CFG_W-1:0]  cfg_min_period;
   logic [CFG_W-1:0]  cfg_step;
   logic [CFG_W-1:0]  cfg_debounce;
   logic [TICK_W-1:0] cfg_tick;

   // Chaser and button state as the block should hold it.
   logic [LED_COUNT-1:0] lit_led;
   logic [PERIOD_W-1:0]  step_period;
   logic [PERIOD_W-1:0]  time_left;
   logic                 fast_level;
   logic                 slow_level;
   logic [PERIOD_W-1:0]  fast_held;
   logic [PERIOD_W-1:0]  slow_held;
   logic                 fast_lock;
   logic                 slow_lock;

   rsp_type expected_samples[$];
   int      results_seen;

   initial mismatches = 0;

   task automatic report(input string msg);
      if (mismatches < 40) $display("MISMATCH: %s", msg);
      mismatches++;
   endtask

   function automatic logic [PERIOD_W-1:0] add_capped(input int unsigned a,
                                                       input int unsigned b);
      int unsigned total;
      total = a + b;
      return (total > 65535) ? 16'hFFFF : PERIOD_W'(total);
   endfunction

   // Works out the result of one button sample and moves the shadow state on.
   function automatic rsp_type chase_sample(input req_type sample);
      int unsigned tick_len;
      int unsigned floor_ms;
      int unsigned chunk;
      logic        fast;
      logic        slow;
      logic        moved;
      rsp_type     outcome;
      fast     = sample.fast_pressed;
      slow     = sample.slow_pressed;
      tick_len = (cfg_tick == 0) ? 1 : cfg_tick;
      floor_ms = (cfg_min_period == 0) ? 1 : cfg_min_period;
      chunk    = (time_left < tick_len) ? time_left : tick_len;
      time_left = time_left - PERIOD_W'(chunk);
      moved    = 1'b0;

      // A chunk with both buttons down only spends its time.
      if (!(fast && slow)) begin
         fast_held  = (fast == fast_level) ? add_capped(fast_held, chunk) : '0;
         fast_level = fast;
         if (fast && fast_held >= cfg_debounce && !fast_lock && !slow) begin
            if (step_period > floor_ms + cfg_step) begin
               step_period = step_period - cfg_step;
            end else begin
               step_period = PERIOD_W'(floor_ms);
            end
            fast_lock = 1'b1;
         end
         if (!fast && fast_lock && fast_held >= cfg_debounce) fast_lock = 1'b0;

         slow_held  = (slow == slow_level) ? add_capped(slow_held, chunk) : '0;
         slow_level = slow;
         if (slow && slow_held >= cfg_debounce && !slow_lock && !fast) begin
            step_period = add_capped(step_period, cfg_step);
            slow_lock   = 1'b1;
         end
         if (!slow && slow_lock && slow_held >= cfg_debounce) slow_lock = 1'b0;
      end

      if (time_left == 0) begin
         lit_led   = {lit_led[LED_COUNT-2:0], lit_led[LED_COUNT-1]};
         time_left = step_period;
         moved     = 1'b1;
      end

      outcome.led_pattern       = LED_OUT_W'(lit_led);
      outcome.current_period_ms = step_period;
      outcome.led_advanced      = moved;
      return outcome;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         cfg_min_period = MIN_PERIOD_RESET;
         cfg_step       = STEP_RESET;
         cfg_debounce   = DEBOUNCE_RESET;
         cfg_tick       = TICK_RESET;
         lit_led        = LED_COUNT'(1);
         step_period    = PERIOD_RESET;
         time_left      = PERIOD_RESET;
         fast_level     = 1'b0;
         slow_level     = 1'b0;
         fast_held      = '0;
         slow_held      = '0;
         fast_lock      = 1'b0;
         slow_lock      = 1'b0;
         results_seen   = 0;
         expected_samples.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_samples.size() == 0) begin
               report($sformatf("result %0d arrived with nothing expected", results_seen));
            end else begin
               want = expected_samples.pop_front();
               if (rsp_data.led_pattern !== want.led_pattern)
                  report($sformatf("result %0d led_pattern %h, expected %h",
                                   results_seen, rsp_data.led_pattern, want.led_pattern));
               if (rsp_data.current_period_ms !== want.current_period_ms)
                  report($sformatf("result %0d current_period_ms %0d, expected %0d",
                                   results_seen, rsp_data.current_period_ms,
                                   want.current_period_ms));
               if (rsp_data.led_advanced !== want.led_advanced)
                  report($sformatf("result %0d led_advanced %b, expected %b",
                                   results_seen, rsp_data.led_advanced, want.led_advanced));
            end
            results_seen++;
         end
         if (req_valid && !req_stall) expected_samples.push_back(chase_sample(req_data));
         if (csr_we) begin
            case (csr_index)
               CSR_MIN_PERIOD: cfg_min_period = csr_wdata;
               CSR_STEP:       cfg_step       = csr_wdata;
               CSR_DEBOUNCE:   cfg_debounce   = csr_wdata;
               CSR_TICK:       cfg_tick       = csr_wdata[TICK_W-1:0];
               default: ;
            endcase
         end
      end
      results_owed <= expected_samples.size();
   end

endmodule

@@ dv/tb_led_chaser_button_speed_core.sv @@
module tb_led_chaser_button_speed_core;
   timeunit 1ns;
   timeprecision 1ps;

   import lcbs_pkg::*;

   localparam int LEDS       = 8;
   localparam int STUCK_LIMIT = 1000;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   req_type          req_data  = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   rsp_type          rsp_data;
   logic             csr_we    = 1'b0;
   csr_index_type    csr_index = CSR_MIN_PERIOD;
   logic [CFG_W-1:0] csr_wdata = '0;

   int   results_owed;
   int   mismatches;
   int   samples_sent = 0;
   int   stuck_cycles = 0;
   logic no_idle      = 1'b0;

   led_chaser_button_speed_core #(.LED_COUNT(LEDS)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   lcbs_chaser_checker #(.LED_COUNT(LEDS)) checker_i (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .results_owed (results_owed),
      .mismatches   (mismatches)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_stall <= !no_idle && ($urandom_range(99) < 33);
   end

   // Ends the run if the block stops taking or giving items.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
         $display("led_chaser_button_speed_core test failed");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   task automatic send_sample(input logic fast, input logic slow);
      req_type sample;
      sample.fast_pressed = fast;
      sample.slow_pressed = slow;
      while (!no_idle && $urandom_range(99) < 33) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= sample;
      do @(posedge clock); while (req_stall);
      samples_sent++;
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (results_owed != 0);
   endtask

   task automatic load_config(input logic [CFG_W-1:0] min_ms, input logic [CFG_W-1:0] step_ms,
                              input logic [CFG_W-1:0] settle_ms,
                              input logic [CFG_W-1:0] tick_word);
      wait_for_results();
      csr_we    <= 1'b1;
      csr_index <= CSR_MIN_PERIOD;
      csr_wdata <= min_ms;
      @(posedge clock);
      csr_index <= CSR_STEP;
      csr_wdata <= step_ms;
      @(posedge clock);
      csr_index <= CSR_DEBOUNCE;
      csr_wdata <= settle_ms;
      @(posedge clock);
      csr_index <= CSR_TICK;
      csr_wdata <= tick_word;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Mostly short periods and debounce times so that presses and LED moves
   // are frequent, with the extremes mixed in.
   task automatic random_config();
      logic [CFG_W-1:0] min_ms;
      logic [CFG_W-1:0] step_ms;
      logic [CFG_W-1:0] settle_ms;
      logic [CFG_W-1:0] tick_word;
      case ($urandom_range(9))
         0:       min_ms = '0;
         1:       min_ms = '1;
         2:       min_ms = 10'd1000;
         default: min_ms = CFG_W'($urandom_range(1, 40));
      endcase
      case ($urandom_range(9))
         0:       step_ms = '0;
         1:       step_ms = '1;
         default: step_ms = CFG_W'($urandom_range(1, 40));
      endcase
      case ($urandom_range(9))
         0:       settle_ms = '0;
         1:       settle_ms = '1;
         default: settle_ms = CFG_W'($urandom_range(0, 40));
      endcase
      case ($urandom_range(9))
         0:       tick_word = '0;
         1:       tick_word = 10'd127;
         default: tick_word = CFG_W'($urandom_range(1, 20));
      endcase
      // The bits above the tick field are don't-care on write.
      if ($urandom_range(3) == 0) tick_word[CFG_W-1:TICK_W] = 3'($urandom_range(7));
      load_config(min_ms, step_ms, settle_ms, tick_word);
   endtask

   // One press of a button (or of both, or random chatter) followed by a release.
   task automatic press_run();
      int   kind;
      int   hold;
      int   gap;
      logic fast;
      logic slow;
      kind = $urandom_range(99);
      hold = $urandom_range(1, 12);
      gap  = $urandom_range(1, 12);
      fast = (kind < 40) || (kind >= 80 && kind < 90);
      slow = (kind >= 40 && kind < 90);
      repeat (hold) begin
         if (kind >= 90) begin
            send_sample(1'($urandom_range(1)), 1'($urandom_range(1)));
         end else if ($urandom_range(19) == 0) begin
            send_sample(!fast, slow);
         end else begin
            send_sample(fast, slow);
         end
      end
      repeat (gap) send_sample(1'b0, $urandom_range(29) == 0);
   endtask

   task automatic run_presses(input int count);
      int target;
      target = samples_sent + count;
      while (samples_sent < target) press_run();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Default settings: the fast press is taken once it has held 40 ms.
      send_sample(1'b0, 1'b0);
      repeat (9) send_sample(1'b1, 1'b0);
      repeat (2) send_sample(1'b1, 1'b1);

      // Zero tick, zero minimum and zero debounce.
      load_config('0, '1, '0, '0);
      send_sample(1'b1, 1'b0);
      send_sample(1'b0, 1'b0);
      send_sample(1'b0, 1'b1);
      send_sample(1'b0, 1'b0);
      send_sample(1'b0, 1'b1);
      send_sample(1'b1, 1'b1);

      // Drive the period up into saturation, then back down to the minimum.
      load_config('1, '1, '0, 10'd127);
      repeat (64) begin
         send_sample(1'b0, 1'b1);
         send_sample(1'b0, 1'b0);
      end
      repeat (64) begin
         send_sample(1'b1, 1'b0);
         send_sample(1'b0, 1'b0);
      end

      // A long hold keeps the stable-time counter climbing far past the debounce time.
      load_config(10'd1, 10'd1, '1, 10'd127);
      repeat (520) send_sample(1'b1, 1'b0);
      repeat (10) send_sample(1'b0, 1'b0);

      for (int phase = 0; phase < 8; phase++) begin
         random_config();
         if (phase == 3) no_idle <= 1'b1;
         run_presses(50);
         if (phase == 5) wait_for_results();
         run_presses(55);
         no_idle <= 1'b0;
      end

      wait_for_results();
      repeat (4) @(posedge clock);
      if (mismatches == 0) begin
         $display("led_chaser_button_speed_core test passed");
      end else begin
         $display("led_chaser_button_speed_core test failed");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+src
src/lcbs_pkg.sv
src/lcbs_button.sv
src/led_chaser_button_speed_core.sv
dv/lcbs_chaser_checker.sv
dv/tb_led_chaser_button_speed_core.sv
